/* rtl/core/clcr_pkg.sv */
// Package for the console line capture ring: sizes, command codes, state codes
// and the pointer wrap helper.
// No dependencies.
package clcr_pkg;

  localparam int RING_DEPTH = 16384;
  localparam int LINE_LEN   = 256;

  localparam int PTR_W  = $clog2(RING_DEPTH);
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int LEN_W  = $clog2(LINE_LEN);
  localparam int FILL_W = 15;
  localparam int PEND_W = 8;
  localparam int SEQ_W  = 32;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_FLUSH = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FL_RD = 5'b00010,
    S_FL_WR = 5'b00100,
    S_FL_LF = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  // Advance a ring pointer by one, wrapping at the ring depth.
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] res;
    if (p == PTR_W'(RING_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = p + PTR_W'(1);
    end
    return res;
  endfunction

endpackage

/* rtl/core/console_line_capture_ring_top.sv */
// Console line capture ring: line assembly, flush into a byte ring that
// overwrites its oldest bytes, byte read-out and clear.
// Depends on clcr_pkg.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  in      | to block  | in_valid/in_stall  | command, char_in
//  out     | from block| out_valid/out_stall| read_byte, byte_valid, fill_count,
//          |           |                    | lost_flag, line_seq, pending_length
//
// Sequencing: one item at a time. Put of an ordinary character, read, clear and
// an empty flush go through accept, then result. A flush of a line of N
// characters moves each byte by a read, then a write, then writes the LF: the
// single line store port and the single ring write port serve one byte at a time.
// Reset: rst clears pointers, counts, flags, sequence and the sequencer; the
// ring and line stores are not cleared and need no clearing pass.
// Stalls: in_stall is high whenever an item is in progress. A finished result
// waits in the output register under out_stall while the next item is taken.
module console_line_capture_ring_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   command,
  input  logic [7:0]                   char_in,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   read_byte,
  output logic                         byte_valid,
  output logic [clcr_pkg::FILL_W-1:0]  fill_count,
  output logic                         lost_flag,
  output logic [clcr_pkg::SEQ_W-1:0]   line_seq,
  output logic [clcr_pkg::PEND_W-1:0]  pending_length
);

  clcr_pkg::state_t state;

  // Architectural state
  logic [clcr_pkg::PTR_W-1:0] wp;
  logic [clcr_pkg::PTR_W-1:0] rp;
  logic [clcr_pkg::CNT_W-1:0] held;
  logic                       lost;
  logic                       after_cr;
  logic [clcr_pkg::LEN_W-1:0] len;
  logic [clcr_pkg::SEQ_W-1:0] seq;

  // Item in progress
  logic [clcr_pkg::LEN_W-1:0] idx;
  logic [7:0]                 ch_q;
  logic                       store_q;  // put the held character after the flush
  logic                       rd_hit;   // read command took a byte

  // Memories
  logic [7:0] ring_mem [clcr_pkg::RING_DEPTH];
  logic [7:0] line_mem [clcr_pkg::LINE_LEN];
  logic [7:0] ring_q;
  logic [7:0] line_q;

  logic                       accept;
  logic                       is_eol;
  logic                       ring_full;
  logic                       ring_we;
  logic [7:0]                 ring_wdata;
  logic                       ring_re;
  logic                       line_we;
  logic [clcr_pkg::LEN_W-1:0] line_waddr;
  logic [7:0]                 line_wdata;
  logic                       line_re;
  logic                       line_at_cut;
  logic [clcr_pkg::PTR_W-1:0] wp_inc;
  logic [clcr_pkg::PTR_W-1:0] rp_inc;

  assign in_stall  = (state != clcr_pkg::S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign is_eol    = (char_in == clcr_pkg::CH_LF) || (char_in == clcr_pkg::CH_CR);
  assign ring_full = (held == clcr_pkg::CNT_W'(clcr_pkg::RING_DEPTH));
  assign line_at_cut = (len >= clcr_pkg::LEN_W'(clcr_pkg::LINE_LEN - 1));

  // Separate pointer advance for the write and read pointers
  assign wp_inc = clcr_pkg::ptr_inc(wp);
  assign rp_inc = clcr_pkg::ptr_inc(rp);

  // Memory port control
  always_comb begin
    ring_we    = (state == clcr_pkg::S_FL_WR) || (state == clcr_pkg::S_FL_LF);
    ring_wdata = (state == clcr_pkg::S_FL_WR) ? line_q : clcr_pkg::CH_LF;
    ring_re    = accept && (command == clcr_pkg::CMD_READ) && (held != '0);
    line_re    = (state == clcr_pkg::S_FL_RD) && (idx < len);
    line_we    = 1'b0;
    line_waddr = len;
    line_wdata = char_in;
    if (accept && (command == clcr_pkg::CMD_PUT) && !is_eol && !line_at_cut) begin
      line_we = 1'b1;
    end else if ((state == clcr_pkg::S_FL_LF) && store_q) begin
      line_we    = 1'b1;
      line_waddr = '0;
      line_wdata = ch_q;
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[wp] <= ring_wdata;
    end
    if (ring_re) begin
      ring_q <= ring_mem[rp];
    end
  end

  always_ff @(posedge clk) begin
    if (line_we) begin
      line_mem[line_waddr] <= line_wdata;
    end
    if (line_re) begin
      line_q <= line_mem[idx];
    end
  end

  // Sequencer and state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= clcr_pkg::S_IDLE;
      wp        <= '0;
      rp        <= '0;
      held      <= '0;
      lost      <= 1'b0;
      after_cr  <= 1'b0;
      len       <= '0;
      seq       <= '0;
      idx       <= '0;
      store_q   <= 1'b0;
      rd_hit    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // drop a taken result; in S_DONE the result register is handled below
      if (out_valid && !out_stall && (state != clcr_pkg::S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        clcr_pkg::S_IDLE: begin
          if (accept) begin
            ch_q    <= char_in;
            idx     <= '0;
            // hold the character for slot 0 when it cuts a full line
            store_q <= (command == clcr_pkg::CMD_PUT) && !is_eol && line_at_cut;
            rd_hit  <= (command == clcr_pkg::CMD_READ) && (held != '0);
            case (command)
              clcr_pkg::CMD_PUT: begin
                if (is_eol) begin
                  if ((char_in == clcr_pkg::CH_LF) && after_cr) begin
                    // drop the LF of a CR LF pair
                    after_cr <= 1'b0;
                    state    <= clcr_pkg::S_DONE;
                  end else begin
                    after_cr <= (char_in == clcr_pkg::CH_CR);
                    state    <= (len != '0) ? clcr_pkg::S_FL_RD : clcr_pkg::S_DONE;
                  end
                end else begin
                  after_cr <= 1'b0;
                  if (line_at_cut) begin
                    // cut the full line first
                    state <= clcr_pkg::S_FL_RD;
                  end else begin
                    len   <= len + clcr_pkg::LEN_W'(1);
                    state <= clcr_pkg::S_DONE;
                  end
                end
              end
              clcr_pkg::CMD_FLUSH: begin
                state <= (len != '0) ? clcr_pkg::S_FL_RD : clcr_pkg::S_DONE;
              end
              clcr_pkg::CMD_READ: begin
                if (held != '0) begin
                  rp   <= rp_inc;
                  held <= held - clcr_pkg::CNT_W'(1);
                end
                state <= clcr_pkg::S_DONE;
              end
              default: begin
                wp       <= '0;
                rp       <= '0;
                held     <= '0;
                lost     <= 1'b0;
                after_cr <= 1'b0;
                len      <= '0;
                state    <= clcr_pkg::S_DONE;
              end
            endcase
          end
        end
        clcr_pkg::S_FL_RD: begin
          state <= (idx < len) ? clcr_pkg::S_FL_WR : clcr_pkg::S_FL_LF;
        end
        clcr_pkg::S_FL_WR, clcr_pkg::S_FL_LF: begin
          // push one byte; on a full ring advance the oldest byte too
          wp <= wp_inc;
          if (ring_full) begin
            rp   <= rp_inc;
            lost <= 1'b1;
          end else begin
            held <= held + clcr_pkg::CNT_W'(1);
          end
          if (state == clcr_pkg::S_FL_WR) begin
            idx   <= idx + clcr_pkg::LEN_W'(1);
            state <= clcr_pkg::S_FL_RD;
          end else begin
            seq   <= seq + clcr_pkg::SEQ_W'(1);
            len   <= store_q ? clcr_pkg::LEN_W'(1) : '0;
            state <= clcr_pkg::S_DONE;
          end
        end
        clcr_pkg::S_DONE: begin
          // hold the result until the output register is free
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            read_byte      <= rd_hit ? ring_q : 8'd0;
            byte_valid     <= rd_hit;
            fill_count     <= clcr_pkg::FILL_W'(held);
            lost_flag      <= lost;
            line_seq       <= seq;
            pending_length <= clcr_pkg::PEND_W'(len);
            state          <= clcr_pkg::S_IDLE;
          end
        end
        default: begin
          state <= clcr_pkg::S_IDLE;
        end
      endcase
    end
  end

  // Pointer consistency: the write pointer leads the read pointer by the count
  logic [clcr_pkg::CNT_W:0]   ptr_sum;
  logic [clcr_pkg::PTR_W-1:0] wp_expect;

  always_comb begin
    ptr_sum = (clcr_pkg::CNT_W+1)'(rp) + (clcr_pkg::CNT_W+1)'(held);
    if (ptr_sum >= (clcr_pkg::CNT_W+1)'(clcr_pkg::RING_DEPTH)) begin
      ptr_sum = ptr_sum - (clcr_pkg::CNT_W+1)'(clcr_pkg::RING_DEPTH);
    end
    wp_expect = clcr_pkg::PTR_W'(ptr_sum);
  end

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= clcr_pkg::CNT_W'(clcr_pkg::RING_DEPTH))
    else $error("ring count exceeds depth");

  a_ptr_consistent: assert property (@(posedge clk) disable iff (rst)
    wp == wp_expect)
    else $error("ring pointers disagree with count");

  a_lost_when_full: assert property (@(posedge clk) disable iff (rst)
    $rose(lost) |-> ring_full)
    else $error("lost flag set while ring not full");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != clcr_pkg::S_IDLE))
    else $error("sequencer idle right after accepting an item");

  a_line_short: assert property (@(posedge clk) disable iff (rst)
    len < clcr_pkg::LEN_W'(clcr_pkg::LINE_LEN - 1) || state != clcr_pkg::S_IDLE
      || len == clcr_pkg::LEN_W'(clcr_pkg::LINE_LEN - 1))
    else $error("pending line too long");

endmodule

/* test/clcr_checker.sv */
// Checker for the console line capture ring: follows accepted items, predicts
// the status result of each one and compares it with what the block returns.
// Depends on clcr_pkg.
module clcr_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [1:0]                  command,
  input  logic [7:0]                  char_in,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [7:0]                  read_byte,
  input  logic                        byte_valid,
  input  logic [clcr_pkg::FILL_W-1:0] fill_count,
  input  logic                        lost_flag,
  input  logic [clcr_pkg::SEQ_W-1:0]  line_seq,
  input  logic [clcr_pkg::PEND_W-1:0] pending_length,
  output int                          fail_count,
  output int                          waiting
);

  typedef struct {
    logic [7:0]                  rbyte;
    logic                        got_byte;
    logic [clcr_pkg::FILL_W-1:0] fill;
    logic                        lost;
    logic [clcr_pkg::SEQ_W-1:0]  seq;
    logic [clcr_pkg::PEND_W-1:0] pend;
  } ring_status_t;

  logic [7:0]                 ring_mem [clcr_pkg::RING_DEPTH];
  logic [7:0]                 line_mem [clcr_pkg::LINE_LEN];
  int unsigned                wr_pos;
  int unsigned                rd_pos;
  int unsigned                held;
  int unsigned                line_len;
  logic                       lost_mark;
  logic                       cr_seen;
  logic [clcr_pkg::SEQ_W-1:0] flushes;
  ring_status_t               status_q[$];

  function automatic int unsigned wrap_next(input int unsigned p);
    return (p + 1 >= clcr_pkg::RING_DEPTH) ? 0 : p + 1;
  endfunction

  // Append one byte; a full ring drops its oldest byte and marks the loss.
  task automatic ring_append(input logic [7:0] b);
    ring_mem[wr_pos] = b;
    wr_pos = wrap_next(wr_pos);
    if (held >= clcr_pkg::RING_DEPTH) begin
      held      = clcr_pkg::RING_DEPTH;
      rd_pos    = wrap_next(rd_pos);
      lost_mark = 1'b1;
    end else begin
      held++;
    end
  endtask

  task automatic commit_line();
    for (int i = 0; i < line_len; i++) begin
      ring_append(line_mem[i]);
    end
    ring_append(clcr_pkg::CH_LF);
    line_len = 0;
    flushes++;
  endtask

  task automatic take_char(input logic [7:0] c);
    if (c == clcr_pkg::CH_LF || c == clcr_pkg::CH_CR) begin
      if (c == clcr_pkg::CH_LF && cr_seen) begin
        cr_seen = 1'b0;
      end else begin
        cr_seen = (c == clcr_pkg::CH_CR);
        if (line_len > 0) begin
          commit_line();
        end
      end
    end else begin
      cr_seen = 1'b0;
      if (line_len >= clcr_pkg::LINE_LEN - 1) begin
        commit_line();
      end
      line_mem[line_len] = c;
      line_len++;
    end
  endtask

  task automatic predict_item(input clcr_pkg::cmd_t cmd, input logic [7:0] c);
    ring_status_t s;
    s.rbyte    = '0;
    s.got_byte = 1'b0;
    case (cmd)
      clcr_pkg::CMD_PUT: begin
        take_char(c);
      end
      clcr_pkg::CMD_FLUSH: begin
        if (line_len > 0) begin
          commit_line();
        end
      end
      clcr_pkg::CMD_READ: begin
        if (held > 0) begin
          s.rbyte    = ring_mem[rd_pos];
          s.got_byte = 1'b1;
          rd_pos     = wrap_next(rd_pos);
          held--;
        end
      end
      default: begin
        wr_pos    = 0;
        rd_pos    = 0;
        held      = 0;
        lost_mark = 1'b0;
        cr_seen   = 1'b0;
        line_len  = 0;
      end
    endcase
    s.fill = clcr_pkg::FILL_W'(held);
    s.lost = lost_mark;
    s.seq  = flushes;
    s.pend = clcr_pkg::PEND_W'(line_len);
    status_q.push_back(s);
  endtask

  task automatic check_result();
    ring_status_t e;
    if (status_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("unexpected result: rb=%h v=%b fill=%0d lost=%b seq=%0d pend=%0d",
                 read_byte, byte_valid, fill_count, lost_flag, line_seq, pending_length);
      end
    end else begin
      e = status_q.pop_front();
      if (e.rbyte !== read_byte || e.got_byte !== byte_valid || e.fill !== fill_count ||
          e.lost !== lost_flag || e.seq !== line_seq || e.pend !== pending_length) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("mismatch exp: rb=%h v=%b fill=%0d lost=%b seq=%0d pend=%0d",
                   e.rbyte, e.got_byte, e.fill, e.lost, e.seq, e.pend);
          $display("         got: rb=%h v=%b fill=%0d lost=%b seq=%0d pend=%0d",
                   read_byte, byte_valid, fill_count, lost_flag, line_seq, pending_length);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      wr_pos    = 0;
      rd_pos    = 0;
      held      = 0;
      line_len  = 0;
      lost_mark = 1'b0;
      cr_seen   = 1'b0;
      flushes   = '0;
      status_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        check_result();
      end
      if (in_valid && !in_stall) begin
        predict_item(clcr_pkg::cmd_t'(command), char_in);
      end
    end
    waiting <= status_q.size();
  end

endmodule

/* test/console_line_capture_ring_top_tb.sv */
// Testbench top for the console line capture ring: clock, reset, item
// stimulus with bursty sending and patterned output stalls, and the verdict.
// Depends on clcr_pkg, console_line_capture_ring_top and clcr_checker.
module console_line_capture_ring_top_tb;

  localparam int MIX_ITEMS    = 450;
  // One full-length line at the cut limit, ended in one of the usual ways or left open.
  localparam int FILL_LINES   = 1;
  localparam int READ_OUT     = 100;
  // Longest item is a full line flush, each byte a read and a write; add margin.
  localparam int DRAIN_CYCLES = 2 * clcr_pkg::LINE_LEN + 100;
  localparam int CYCLE_LIMIT  = 400_000;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY} rx_mode_t;
  typedef enum int {END_NONE, END_CR, END_LF, END_CRLF, END_FLUSH} line_end_t;

  logic                        clk      = 1'b0;
  logic                        rst      = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [1:0]                  command  = clcr_pkg::CMD_PUT;
  logic [7:0]                  char_in  = 8'h00;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [7:0]                  read_byte;
  logic                        byte_valid;
  logic [clcr_pkg::FILL_W-1:0] fill_count;
  logic                        lost_flag;
  logic [clcr_pkg::SEQ_W-1:0]  line_seq;
  logic [clcr_pkg::PEND_W-1:0] pending_length;

  int       fail_count;
  int       waiting;
  int       items_sent  = 0;
  int       burst_left  = 0;
  int       cycle_count = 0;
  rx_mode_t rx_mode     = RX_FREE;
  int       rx_left     = 0;

  always #4 clk = ~clk;

  console_line_capture_ring_top u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command        (command),
    .char_in        (char_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .read_byte      (read_byte),
    .byte_valid     (byte_valid),
    .fill_count     (fill_count),
    .lost_flag      (lost_flag),
    .line_seq       (line_seq),
    .pending_length (pending_length)
  );

  clcr_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command        (command),
    .char_in        (char_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .read_byte      (read_byte),
    .byte_valid     (byte_valid),
    .fill_count     (fill_count),
    .lost_flag      (lost_flag),
    .line_seq       (line_seq),
    .pending_length (pending_length),
    .fail_count     (fail_count),
    .waiting        (waiting)
  );

  // Stop a hung run; a correct one ends far below this count.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver stalls: switch between free-flowing, light and heavy stalling
  // for randomly chosen stretches, so stalls land on every phase of a flush
  // and some stretches see no stall at all.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 2));
      rx_left <= $urandom_range(20, 300);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_FREE:  out_stall <= 1'b0;
      RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      default:  out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Present one item and hold it until accepted. Between bursts, drop valid
  // for a random gap; inside a burst, valid stays high from item to item.
  task automatic send_item(input clcr_pkg::cmd_t c, input logic [7:0] ch);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      // Mostly short bursts, now and then a long unbroken stream.
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    command  <= c;
    char_in  <= ch;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Random byte that is neither CR nor LF: flip bit 5 to move off either.
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (c == clcr_pkg::CH_LF || c == clcr_pkg::CH_CR) begin
      c = c ^ 8'h20;
    end
    return c;
  endfunction

  task automatic send_line(input int len, input line_end_t ending);
    for (int i = 0; i < len; i++) begin
      send_item(clcr_pkg::CMD_PUT, plain_char());
    end
    case (ending)
      END_CR:    send_item(clcr_pkg::CMD_PUT, clcr_pkg::CH_CR);
      END_LF:    send_item(clcr_pkg::CMD_PUT, clcr_pkg::CH_LF);
      END_CRLF: begin
        send_item(clcr_pkg::CMD_PUT, clcr_pkg::CH_CR);
        send_item(clcr_pkg::CMD_PUT, clcr_pkg::CH_LF);
      end
      END_FLUSH: send_item(clcr_pkg::CMD_FLUSH, 8'($urandom_range(0, 255)));
      default: ;
    endcase
  endtask

  // Mostly well-formed lines with random content, read bursts that drain
  // part of the ring, rare clears, and some noise with put, flush or read and any byte.
  task automatic run_mix(input int target);
    int start;
    int pick;
    int len;
    int reads;
    logic [7:0] ch;
    start = items_sent;
    while (items_sent - start < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        // A few lines run right up to the cut length and past it.
        len = (pick < 5) ? $urandom_range(clcr_pkg::LINE_LEN - 6, clcr_pkg::LINE_LEN)
                         : $urandom_range(0, 16);
        send_line(len, line_end_t'($urandom_range(0, 4)));
      end else if (pick < 80) begin
        reads = $urandom_range(1, 20);
        repeat (reads) send_item(clcr_pkg::CMD_READ, 8'($urandom_range(0, 255)));
      end else if (pick < 83) begin
        send_item(clcr_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)));
      end else begin
        case ($urandom_range(0, 2))
          0:       ch = clcr_pkg::CH_CR;
          1:       ch = clcr_pkg::CH_LF;
          default: ch = 8'($urandom_range(0, 255));
        endcase
        send_item(clcr_pkg::cmd_t'($urandom_range(0, 2)), ch);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed opening: empty ring and empty line first.
    send_item(clcr_pkg::CMD_READ,  8'hFF);          // read on empty ring returns nothing
    send_item(clcr_pkg::CMD_FLUSH, 8'h00);          // flush of an empty line does nothing
    send_item(clcr_pkg::CMD_PUT,   clcr_pkg::CH_CR); // empty line, no flush counted
    send_item(clcr_pkg::CMD_PUT,   clcr_pkg::CH_LF); // LF right after CR is dropped
    send_item(clcr_pkg::CMD_PUT,   clcr_pkg::CH_LF); // lone LF on empty line
    // Byte extremes are ordinary characters, zero included.
    send_item(clcr_pkg::CMD_PUT,   8'h00);
    send_item(clcr_pkg::CMD_PUT,   8'hFF);
    send_item(clcr_pkg::CMD_PUT,   8'h80);
    send_item(clcr_pkg::CMD_PUT,   8'h7F);
    send_item(clcr_pkg::CMD_PUT,   clcr_pkg::CH_CR); // ends the line
    send_item(clcr_pkg::CMD_FLUSH, 8'hAA);          // flush must keep the after-CR state
    send_item(clcr_pkg::CMD_PUT,   clcr_pkg::CH_LF); // so this LF is still dropped
    send_item(clcr_pkg::CMD_PUT,   8'h0C);          // neighbors of CR and LF
    send_item(clcr_pkg::CMD_PUT,   8'h0E);
    send_item(clcr_pkg::CMD_READ,  8'h55);          // read leaves the pending line alone
    send_item(clcr_pkg::CMD_FLUSH, 8'h00);          // forced flush of a partial line
    repeat (6) send_item(clcr_pkg::CMD_READ, 8'($urandom_range(0, 255)));
    send_item(clcr_pkg::CMD_PUT,   8'h41);
    send_item(clcr_pkg::CMD_PUT,   clcr_pkg::CH_CR);
    send_item(clcr_pkg::CMD_CLEAR, 8'h00);          // clear with ring bytes, after-CR set
    send_item(clcr_pkg::CMD_PUT,   clcr_pkg::CH_LF);
    send_item(clcr_pkg::CMD_READ,  8'h00);

    run_mix(MIX_ITEMS);

    // Full-length line: CR, CR LF or a forced flush at the limit, or no ending.
    for (int n = 0; n < FILL_LINES; n++) begin
      case ($urandom_range(0, 3))
        0:       send_line(clcr_pkg::LINE_LEN - 1, END_CR);
        1:       send_line(clcr_pkg::LINE_LEN - 1, END_FLUSH);
        2:       send_line(clcr_pkg::LINE_LEN - 1, END_CRLF);
        default: send_line(clcr_pkg::LINE_LEN - 1, END_NONE);
      endcase
    end
    repeat (READ_OUT) send_item(clcr_pkg::CMD_READ, 8'($urandom_range(0, 255)));
    run_mix(60);
    send_item(clcr_pkg::CMD_CLEAR, 8'h00);          // clear after a long run
    run_mix(30);

    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && waiting == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
